FILE: sv/robpc_pkg.sv
// ----------------------------------------------------------------------------
// robpc_pkg
// Shared types, register indexes and widths of the ray / oriented box crop.
// ----------------------------------------------------------------------------
package robpc_pkg;

  localparam int unsigned MaxCloudPoints = 65536;
  localparam int unsigned CfgW = 48;
  localparam int unsigned CfgIdxW = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_BOX_ORIGIN = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROT_COL0   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROT_COL1   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ROT_COL2   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HALF_SIZE  = 3'd4;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic               point_finite;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic [15:0] point_index;
    logic        ray_hit;
    logic        occluding;
    logic        inside_box;
    logic [15:0] hit_count;
    logic [15:0] occluding_count;
    logic        cloud_done;
  } out_item_t;

  // item handed from the front to the back: point plus its sequence number
  typedef struct packed {
    in_item_t    pt;
    logic [15:0] idx;
  } front_item_t;

  // classification record; no module in the project uses it
  typedef struct packed {
    logic        hit;
    logic        occ;
    logic        ins;
    logic [15:0] idx;
    logic        last;
  } class_t;

endpackage

FILE: sv/robpc_front.sv
// ----------------------------------------------------------------------------
// robpc_front
// Accepts points, numbers them and feeds a short queue towards the back part.
// ----------------------------------------------------------------------------
module robpc_front #(
  parameter int unsigned MAX_CLOUD_POINTS = robpc_pkg::MaxCloudPoints
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  robpc_pkg::in_item_t    in_data,
  output logic                   q_valid,
  input  logic                   q_pop,
  output robpc_pkg::front_item_t q_data
);

  localparam int unsigned Depth = 2;

  robpc_pkg::front_item_t mem_r [Depth];
  logic                   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]             cnt_r, cnt_nxt;
  logic [15:0]            idx_r, idx_nxt;
  logic                   push;
  logic [16:0]            nx;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  // point numbering, wraps at the cloud size or 16 bits and restarts after a last point
  always_comb begin
    nx = {1'b0, idx_r} + 17'd1;
    idx_nxt = idx_r;
    if (push) begin
      if (in_data.last_point) idx_nxt = '0;
      else if ({15'd0, nx} >= MAX_CLOUD_POINTS || nx[16]) idx_nxt = '0;
      else idx_nxt = nx[15:0];
    end
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0; idx_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt; idx_r <= idx_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{pt: in_data, idx: idx_r};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");

endmodule

FILE: sv/robpc_divider.sv
// ----------------------------------------------------------------------------
// robpc_divider
// Shared restoring unit: signed division truncated toward zero and, in root
// mode, floor square root; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module robpc_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               sqrt_mode,
  input  logic signed [79:0] num,
  input  logic signed [47:0] den,
  output logic               done,
  output logic signed [79:0] quo
);

  logic [79:0] rem_r, rem_nxt;
  logic [79:0] q_r, q_nxt;
  logic [79:0] d_r;
  logic [80:0] acc_r, acc_nxt;
  logic [6:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt, neg_r, sq_r;
  logic [80:0] trial;
  logic [79:0] bit_r, bit_nxt;

  assign done = busy_r && (step_r == 7'd0);
  assign quo  = neg_r ? -$signed(q_r) : $signed(q_r);

  always_comb begin
    rem_nxt = rem_r; q_nxt = q_r; acc_nxt = acc_r; step_nxt = step_r;
    busy_nxt = busy_r; bit_nxt = bit_r; trial = '0;
    if (start) begin
      busy_nxt = 1'b1;
      if (sqrt_mode) begin
        rem_nxt = num; q_nxt = '0; bit_nxt = 80'd1 << 78; step_nxt = 7'd40;
      end else begin
        rem_nxt = num[79] ? 80'(-num) : 80'(num);
        q_nxt = '0; acc_nxt = '0; step_nxt = 7'd80;
      end
    end else if (busy_r && step_r != 7'd0) begin
      step_nxt = step_r - 7'd1;
      if (sq_r) begin
        trial = {1'b0, q_r} + {1'b0, bit_r};
        if ({1'b0, rem_r} >= trial) begin
          rem_nxt = rem_r - trial[79:0];
          q_nxt = (q_r >> 1) + bit_r;
        end else begin
          q_nxt = q_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end else begin
        trial = {acc_r[79:0], rem_r[79]};
        rem_nxt = rem_r << 1;
        if (trial >= {1'b0, d_r}) begin
          acc_nxt = trial - {1'b0, d_r};
          q_nxt = {q_r[78:0], 1'b1};
        end else begin
          acc_nxt = trial;
          q_nxt = {q_r[78:0], 1'b0};
        end
      end
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; step_r <= '0;
    end else begin
      busy_r <= busy_nxt; step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt; q_r <= q_nxt; acc_r <= acc_nxt; bit_r <= bit_nxt;
    if (start) begin
      sq_r  <= sqrt_mode;
      d_r   <= den[47] ? 80'(-den) : 80'(den);
      neg_r <= !sqrt_mode && (num[79] ^ den[47]);
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r || done) else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("divider done held");
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && step_r != 7'd0 && !start |=> step_r == $past(step_r) - 7'd1)
    else $error("divider step skipped");

endmodule

FILE: sv/robpc_back.sv
// ----------------------------------------------------------------------------
// robpc_back
// Slab test sequencer: length, projections, slab bounds on the shared
// divider, parallel checks, then counting and the output register.
// ----------------------------------------------------------------------------
module robpc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  robpc_pkg::front_item_t q_data,
  input  logic [47:0]            box_origin,
  input  logic [47:0]            rot_col0,
  input  logic [47:0]            rot_col1,
  input  logic [47:0]            rot_col2,
  input  logic [47:0]            half_size,
  output logic                   out_valid,
  input  logic                   out_stall,
  output robpc_pkg::out_item_t   out_data
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SQ    = 9'b000000010,
    S_ROOT  = 9'b000000100,
    S_PROJ  = 9'b000001000,
    S_DIVA  = 9'b000010000,
    S_DIVB  = 9'b000100000,
    S_PCHK  = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  robpc_pkg::front_item_t it_r;
  logic [1:0]  ax_r, ax_nxt;
  logic        pc_r;            // parallel check sub step: 0 lo, 1 hi
  logic [33:0] s_r;
  logic signed [24:0] len_r;    // up to ~2^20
  logic signed [34:0] p_r [3];
  logic signed [34:0] a_r [3];
  logic [2:0]  par_r;
  logic        found_r, miss_r;
  logic signed [79:0] lo_r, hi_r, qa_r;
  logic [15:0] hits_r, occs_r;

  // divider hookup
  logic               dv_start, dv_sqrt, dv_done;
  logic signed [79:0] dv_num, dv_quo;
  logic signed [47:0] dv_den;

  robpc_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .sqrt_mode(dv_sqrt),
    .num(dv_num), .den(dv_den), .done(dv_done), .quo(dv_quo)
  );

  // current axis helpers
  logic [47:0]        col;
  logic signed [34:0] pc, ac, psum;
  logic signed [35:0] hh, ee;
  logic signed [15:0] c0, c1, c2, o0, o1, o2;
  logic signed [32:0] m0, m1, m2, n0, n1, n2;
  logic signed [36:0] nsum;
  logic signed [61:0] nprod;
  logic signed [33:0] tv;       // slab bounds stay below 2^32
  logic signed [21:0] pcn;      // a parallel axis projection stays below 2^21
  logic signed [20:0] lenn;
  logic signed [59:0] base, lim, dd;
  logic [45:0]        pabs;
  logic               dv_busy_r;

  always_comb begin
    case (ax_r)
      2'd0:    col = rot_col0;
      2'd1:    col = rot_col1;
      default: col = rot_col2;
    endcase
    c0 = col[15:0]; c1 = col[31:16]; c2 = col[47:32];
    o0 = box_origin[15:0]; o1 = box_origin[31:16]; o2 = box_origin[47:32];
    m0 = it_r.pt.point_x * c0; m1 = it_r.pt.point_y * c1;
    m2 = it_r.pt.point_z * c2;
    n0 = o0 * c0; n1 = o1 * c1; n2 = o2 * c2;
    psum = 35'(m0) + 35'(m1) + 35'(m2);
    pc = p_r[ax_r]; ac = a_r[ax_r];
    case (ax_r)
      2'd0:    hh = $signed({6'd0, half_size[15:0], 14'd0});
      2'd1:    hh = $signed({6'd0, half_size[31:16], 14'd0});
      default: hh = $signed({6'd0, half_size[47:32], 14'd0});
    endcase
    ee   = (pc > 0) ? hh : -hh;
    pabs = psum[34] ? 46'(-psum) : 46'(psum);
    // slab bound numerator, entry side in S_DIVA and exit side in S_DIVB
    nsum  = (state_r == S_DIVB) ? 37'(ac) + 37'(ee) : 37'(ac) - 37'(ee);
    nprod = nsum * len_r;
    // parallel axis check terms
    lenn = $signed(len_r[20:0]);
    pcn  = $signed(pc[21:0]);
    tv   = pc_r ? $signed(hi_r[33:0]) : $signed(lo_r[33:0]);
    base = ac * lenn;
    lim  = hh * lenn;
    dd   = base - tv * pcn;
  end

  always_comb begin
    state_nxt = state_r; ax_nxt = ax_r;
    dv_start = 1'b0; dv_sqrt = 1'b0; dv_num = '0; dv_den = '0;
    q_pop = 1'b0;
    case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_SQ;
      S_SQ: begin
        dv_start = 1'b1; dv_sqrt = 1'b1; dv_num = 80'({s_r, 8'd0});
        state_nxt = S_ROOT;
      end
      S_ROOT: if (dv_done) state_nxt = S_PROJ;
      S_PROJ: begin
        if (ax_r == 2'd2) begin
          ax_nxt = 2'd0; state_nxt = S_DIVA;
        end else ax_nxt = ax_r + 2'd1;
      end
      S_DIVA: begin
        if (!dv_busy_r) begin
          if (par_r[ax_r]) begin
            if (ax_r == 2'd2) begin ax_nxt = 2'd0; state_nxt = S_PCHK; end
            else ax_nxt = ax_r + 2'd1;
          end else begin
            dv_start = 1'b1;
            dv_num = 80'(nprod);
            dv_den = 48'(pc);
          end
        end else if (dv_done) state_nxt = S_DIVB;
      end
      S_DIVB: begin
        if (!dv_busy_r) begin
          dv_start = 1'b1;
          dv_num = 80'(nprod);
          dv_den = 48'(pc);
        end else if (dv_done) begin
          state_nxt = S_DIVA;
          if (ax_r == 2'd2) begin ax_nxt = 2'd0; state_nxt = S_PCHK; end
          else ax_nxt = ax_r + 2'd1;
        end
      end
      S_PCHK: begin
        if (pc_r || !par_r[ax_r] || !found_r) begin
          if (ax_r == 2'd2 || !found_r) begin
            ax_nxt = 2'd0; state_nxt = S_FIN;
          end else ax_nxt = ax_r + 2'd1;
        end
      end
      S_FIN: begin
        q_pop = 1'b1; state_nxt = S_OUT;
      end
      S_OUT: if (!out_valid || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // divider busy tracking
  always_ff @(posedge clk) begin
    if (!rst_n) dv_busy_r <= 1'b0;
    else if (dv_start) dv_busy_r <= 1'b1;
    else if (dv_done) dv_busy_r <= 1'b0;
  end

  // datapath registers
  logic hit_w, occ_w, ins_w;
  logic signed [79:0] lw;
  always_comb begin
    lw = 80'(len_r);
    hit_w = it_r.pt.point_finite && (len_r != 0) && found_r && !miss_r
            && (lo_r <= hi_r);
    occ_w = hit_w && (lw <= lo_r);
    ins_w = hit_w && !occ_w && (lw <= hi_r);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        it_r <= q_data;
        s_r  <= 34'(q_data.pt.point_x * q_data.pt.point_x)
              + 34'(q_data.pt.point_y * q_data.pt.point_y)
              + 34'(q_data.pt.point_z * q_data.pt.point_z);
        found_r <= 1'b0; miss_r <= 1'b0; pc_r <= 1'b0;
      end
      S_ROOT: if (dv_done) len_r <= dv_quo[24:0];
      S_PROJ: begin
        p_r[ax_r] <= psum;
        a_r[ax_r] <= 35'(n0) + 35'(n1) + 35'(n2);
        par_r[ax_r] <= (57'(pabs) * 57'd1000) < (57'(len_r) * 57'd1024);
      end
      S_DIVA: if (dv_done) qa_r <= dv_quo;
      S_DIVB: if (dv_done) begin
        if (!found_r || qa_r > lo_r) lo_r <= qa_r;
        if (!found_r || dv_quo < hi_r) hi_r <= dv_quo;
        found_r <= 1'b1;
      end
      S_PCHK: begin
        if (found_r && par_r[ax_r]) begin
          if ((dd < 0 ? -dd : dd) > lim) miss_r <= 1'b1;
          pc_r <= ~pc_r;
        end
      end
      default: ;
    endcase
  end

  // counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ax_r <= '0; hits_r <= '0; occs_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt; ax_r <= ax_nxt;
      if (state_r == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        out_data.point_index <= it_r.idx;
        out_data.ray_hit <= hit_w;
        out_data.occluding <= occ_w;
        out_data.inside_box <= ins_w;
        out_data.hit_count <= (hit_w && hits_r != 16'hFFFF) ? hits_r + 16'd1 : hits_r;
        out_data.occluding_count <= (occ_w && occs_r != 16'hFFFF) ? occs_r + 16'd1
                                                                  : occs_r;
        out_data.cloud_done <= it_r.pt.last_point;
        if (it_r.pt.last_point) begin
          hits_r <= '0; occs_r <= '0;
        end else begin
          if (hit_w && hits_r != 16'hFFFF) hits_r <= hits_r + 16'd1;
          if (occ_w && occs_r != 16'hFFFF) occs_r <= occs_r + 16'd1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_occ_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.occluding || out_data.ray_hit) else $error("occ without hit");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.occluding && out_data.inside_box)) else $error("occ and inside");
  a_pop_once: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop) else $error("double pop");

endmodule

FILE: sv/ray_oriented_box_point_crop.sv
// ----------------------------------------------------------------------------
// ray_oriented_box_point_crop
// Ray / oriented box slab test per point with running hit and occluder counts.
// ----------------------------------------------------------------------------
// sequence: per point a 40-step root for the length, the projections, then for
//   each non-parallel axis two 80-step divisions on the shared unit, then the
//   checks on parallel axes; the back part works on one point at a time
// flow: a two-entry queue takes points ahead and
//   a stalled result holds the back part until it is taken
// reset: synchronous active-low rst_n clears counters, queue, state and config registers
module ray_oriented_box_point_crop #(
  parameter int unsigned MAX_CLOUD_POINTS = robpc_pkg::MaxCloudPoints
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  robpc_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output robpc_pkg::out_item_t  out_data,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [47:0]           cfg_wdata
);

  logic [47:0] origin_r, col0_r, col1_r, col2_r, half_r;
  logic q_valid, q_pop;
  robpc_pkg::front_item_t q_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0; col0_r <= '0; col1_r <= '0; col2_r <= '0; half_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        robpc_pkg::REG_BOX_ORIGIN: origin_r <= cfg_wdata;
        robpc_pkg::REG_ROT_COL0:   col0_r   <= cfg_wdata;
        robpc_pkg::REG_ROT_COL1:   col1_r   <= cfg_wdata;
        robpc_pkg::REG_ROT_COL2:   col2_r   <= cfg_wdata;
        robpc_pkg::REG_HALF_SIZE:  half_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  robpc_front #(.MAX_CLOUD_POINTS(MAX_CLOUD_POINTS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  robpc_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .box_origin(origin_r), .rot_col0(col0_r), .rot_col1(col1_r),
    .rot_col2(col2_r), .half_size(half_r),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the ray / oriented box point crop. A local fixed-point model of the
// slab test predicts each point's classification and running counts; results
// are compared field by field while both sides idle at random.
// ----------------------------------------------------------------------------
module tb;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  robpc_pkg::in_item_t   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  robpc_pkg::out_item_t  out_data;
  logic                  cfg_we = 1'b0;
  logic [2:0]            cfg_index = robpc_pkg::REG_BOX_ORIGIN;
  logic [47:0]           cfg_wdata = '0;

  // local copy of the box registers and running counts
  logic [47:0] box_org, box_half;
  logic [47:0] box_col [3];
  logic [15:0] next_index, hits_now, occ_now;

  robpc_pkg::out_item_t expected_points [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  ray_oriented_box_point_crop DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  initial begin
    #400_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint lane_signed(logic [47:0] v, int k);
    return longint'($signed(v[16*k +: 16]));
  endfunction

  function automatic longint lane_unsigned(logic [47:0] v, int k);
    return longint'(v[16*k +: 16]);
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'd1 << 40;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // slab test of the ray through p against the configured box
  function automatic bit slab_hit(longint p [3], longint len, output longint t0,
                                  output longint t1);
    longint pr [3], ar [3];
    bit     par [3];
    bit     found;
    longint h, e, a, b, lim, base;
    found = 0;
    t0 = 0;
    t1 = 0;
    for (int i = 0; i < 3; i++) begin
      pr[i] = 0;
      ar[i] = 0;
      for (int j = 0; j < 3; j++) begin
        pr[i] += p[j] * lane_signed(box_col[i], j);
        ar[i] += lane_signed(box_org, j) * lane_signed(box_col[i], j);
      end
      par[i] = mag(pr[i]) * 1000 < len * 1024;
      if (!par[i]) begin
        h = lane_unsigned(box_half, i) << 14;
        e = (pr[i] > 0) ? h : -h;
        a = (ar[i] - e) * len / pr[i];
        b = (ar[i] + e) * len / pr[i];
        if (!found) begin
          t0 = a;
          t1 = b;
          found = 1;
        end else begin
          if (a > t0) t0 = a;
          if (b < t1) t1 = b;
        end
      end
    end
    if (!found || t0 > t1) return 0;
    for (int i = 0; i < 3; i++) begin
      if (par[i]) begin
        lim = (lane_unsigned(box_half, i) * len) << 14;
        base = ar[i] * len;
        if (mag(base - t0 * pr[i]) > lim || mag(base - t1 * pr[i]) > lim) return 0;
      end
    end
    return 1;
  endfunction

  // classify one accepted point and advance the running counts
  function automatic robpc_pkg::out_item_t classify_point(robpc_pkg::in_item_t it);
    robpc_pkg::out_item_t r;
    longint    p [3];
    longint    len, t0, t1;
    r = '0;
    r.point_index = next_index;
    p[0] = longint'(it.point_x);
    p[1] = longint'(it.point_y);
    p[2] = longint'(it.point_z);
    if (it.point_finite) begin
      len = root_floor((p[0] * p[0] + p[1] * p[1] + p[2] * p[2]) << 8);
      if (len > 0 && slab_hit(p, len, t0, t1)) begin
        r.ray_hit = 1'b1;
        if (hits_now != 16'hFFFF) hits_now++;
        if (len <= t0) begin
          r.occluding = 1'b1;
          if (occ_now != 16'hFFFF) occ_now++;
        end else if (len <= t1) begin
          r.inside_box = 1'b1;
        end
      end
    end
    r.hit_count = hits_now;
    r.occluding_count = occ_now;
    r.cloud_done = it.last_point;
    if (it.last_point) begin
      next_index = '0;
      hits_now = '0;
      occ_now = '0;
    end else if (int'(next_index) + 1 >= int'(robpc_pkg::MaxCloudPoints)) begin
      next_index = '0;
    end else begin
      next_index = next_index + 16'd1;
    end
    return r;
  endfunction

  function automatic void field_check(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d got %0d", name, exp_v, got_v);
    end
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    robpc_pkg::out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", out_data);
      end else begin
        e = expected_points.pop_front();
        field_check("point_index", e.point_index, out_data.point_index);
        field_check("ray_hit", e.ray_hit, out_data.ray_hit);
        field_check("occluding", e.occluding, out_data.occluding);
        field_check("inside_box", e.inside_box, out_data.inside_box);
        field_check("hit_count", e.hit_count, out_data.hit_count);
        field_check("occluding_count", e.occluding_count, out_data.occluding_count);
        field_check("cloud_done", e.cloud_done, out_data.cloud_done);
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_point(robpc_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    expected_points.insert(expected_points.size(), classify_point(it));
  endtask

  // wait for every outstanding item, then let the pipeline settle
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // writes all five registers; only while idle
  task automatic load_box(logic [47:0] org, logic [47:0] c0, logic [47:0] c1,
                          logic [47:0] c2, logic [47:0] half);
    logic [47:0] vals [5];
    logic [robpc_pkg::CfgIdxW-1:0] regs [5];
    vals = '{org, c0, c1, c2, half};
    regs = '{robpc_pkg::REG_BOX_ORIGIN, robpc_pkg::REG_ROT_COL0, robpc_pkg::REG_ROT_COL1,
             robpc_pkg::REG_ROT_COL2, robpc_pkg::REG_HALF_SIZE};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    box_org = org;
    box_col[0] = c0;
    box_col[1] = c1;
    box_col[2] = c2;
    box_half = half;
  endtask

  function automatic robpc_pkg::in_item_t make_point(int x, int y, int z, bit fin, bit last);
    robpc_pkg::in_item_t it;
    it.point_x = 16'(x);
    it.point_y = 16'(y);
    it.point_z = 16'(z);
    it.point_finite = fin;
    it.last_point = last;
    return it;
  endfunction

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  // mostly points aimed near the box centre at various ranges, some noise
  function automatic robpc_pkg::in_item_t random_point;
    robpc_pkg::in_item_t it;
    int       sel, k, c [3];
    sel = $urandom_range(99);
    k = $urandom_range(4, 30);
    for (int i = 0; i < 3; i++)
      c[i] = clamp16(((int'(lane_signed(box_org, i)) +
                       int'($urandom_range(0, 12000)) - 6000) * k) / 16);
    it = make_point(c[0], c[1], c[2], 1'b1, $urandom_range(99) < 4);
    if (sel < 20) begin
      it.point_x = 16'($urandom);
      it.point_y = 16'($urandom);
      it.point_z = 16'($urandom);
    end else if (sel < 25) begin
      it.point_finite = 1'b0;
    end else if (sel < 28) begin
      it.point_x = '0;
      it.point_y = '0;
      it.point_z = '0;
    end
    return it;
  endfunction

  function automatic logic [47:0] rand48;
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  // zero registers after reset: every axis parallel, all misses
  task automatic test_reset_registers;
    send_point(make_point(4096, 0, 0, 1, 0));
    send_point(make_point(32767, 32767, 32767, 1, 0));
    send_point(make_point(-32768, -32768, -32768, 1, 1));
    drain();
  endtask

  // hand-picked rays against an axis-aligned unit box two metres down x
  task automatic test_directed_rays;
    load_box({16'd0, 16'd0, 16'd8192}, {32'd0, 16'h4000}, {16'd0, 16'h4000, 16'd0},
             {16'h4000, 32'd0}, {3{16'd2048}});
    send_point(make_point(8192, 0, 0, 1, 0));    // inside
    send_point(make_point(4096, 0, 0, 1, 0));    // occluding
    send_point(make_point(16384, 0, 0, 1, 0));   // passes through
    send_point(make_point(-8192, 0, 0, 1, 0));   // behind sensor
    send_point(make_point(0, 8192, 0, 1, 0));    // off to the side
    send_point(make_point(8192, 1000, -1000, 1, 0));
    send_point(make_point(0, 0, 0, 1, 0));       // zero point
    send_point(make_point(8192, 0, 0, 0, 0));    // not finite
    send_point(make_point(32767, 32767, 32767, 1, 0));
    send_point(make_point(-32768, -32768, -32768, 1, 0));
    send_point(make_point(32767, -32768, -1, 1, 1));
    send_point(make_point(6000, 0, 0, 1, 1));    // fresh cloud of one
    drain();
    // register extremes
    load_box({3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}}, {16'h8000, 16'h7FFF, 16'h8000},
             {3{16'hFFFF}});
    send_point(make_point(-32768, 32767, -32768, 1, 0));
    send_point(make_point(32767, 32767, 32767, 1, 0));
    send_point(make_point(-1, 1, -1, 1, 0));
    send_point(make_point(100, -32768, 5, 1, 1));
    drain();
  endtask

  // one random phase under a given register setting and idling mix
  task automatic test_random_cloud(int n, int s_pct, int r_pct, int box_sel);
    logic [47:0] org;
    drain();
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    org = {16'($urandom_range(0, 16000) - 8000), 16'($urandom_range(0, 16000) - 8000),
           16'($urandom_range(0, 16000) - 8000)};
    case (box_sel)
      0: load_box(org, {32'd0, 16'h4000}, {16'd0, 16'h4000, 16'd0}, {16'h4000, 32'd0},
                  {16'($urandom_range(500, 9000)), 16'($urandom_range(500, 9000)),
                   16'($urandom_range(500, 9000))});
      1: load_box(org, {16'd0, 16'd11585, 16'd11585}, {16'd0, 16'd11585, -16'sd11585},
                  {16'h4000, 32'd0}, {3{16'($urandom_range(1000, 6000))}});
      default: load_box(org, rand48(), rand48(), rand48(),
                        {3{16'($urandom_range(0, 65535))}});
    endcase
    for (int i = 0; i < n; i++) begin
      send_point(random_point());
      // hold off once mid-phase until the block has emptied
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    in_valid = 1'b0;
    box_org = '0;
    box_half = '0;
    for (int i = 0; i < 3; i++) box_col[i] = '0;
    next_index = '0;
    hits_now = '0;
    occ_now = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_registers();
    test_directed_rays();
    test_random_cloud(230, 25, 86, 0);
    test_random_cloud(230, 86, 25, 1);
    test_random_cloud(230, 0, 0, 2);
    drain();

    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
